/* hw/rtl/mbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants for the boundary tracer
// Item codes, register indexes, sequencer states, neighbour table and the
// structs passed to the pixel store.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int COORD_W = 7;    // area is at most 127 wide from the 7-bit register
  localparam int COUNT_W = 13;
  localparam int LIMIT_W = 14;
  localparam logic [LIMIT_W-1:0] POINT_CAP = 14'd8192;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_NEXT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAXPTS = 2'd2;

  // clockwise neighbours, starting north-west
  localparam logic signed [1:0] STEP_DX [0:7] =
    '{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [0:7] =
    '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0};

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRACING,
    PH_DONE,
    PH_BLANK
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_STEP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       en;
    logic [5:0] x;
    logic [5:0] y;
    logic       on;
  } wr_t;

  typedef struct packed {
    logic signed [COORD_W:0] x;
    logic signed [COORD_W:0] y;
  } probe_t;

endpackage

/* hw/rtl/mbt_pixel_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pixel_store: one-bit image memory with area-checked probe port
// One write port for pixel loads, one registered read port; probes outside
// the configured area return zero.
// ----------------------------------------------------------------------------
module mbt_pixel_store #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  mbt_pkg::wr_t                  wr,
  input  mbt_pkg::probe_t               probe,
  input  logic [mbt_pkg::COORD_W-1:0]   area_w,
  input  logic [mbt_pkg::COORD_W-1:0]   area_h,
  output logic                          hit
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          wr_ok;
  logic          in_area;
  logic          in_area_q;
  logic          rd_bit;

  assign wr_ok = wr.en && (32'(wr.x) < MAX_WIDTH) && (32'(wr.y) < MAX_HEIGHT);
  assign waddr = AW'(32'(wr.y) * 32'(MAX_WIDTH) + 32'(wr.x));

  assign in_area = !probe.x[mbt_pkg::COORD_W] && !probe.y[mbt_pkg::COORD_W] &&
                   (probe.x[mbt_pkg::COORD_W-1:0] < area_w) &&
                   (probe.y[mbt_pkg::COORD_W-1:0] < area_h);

  // address only matters inside the area, which never exceeds the store
  assign raddr = in_area ?
    AW'(32'(probe.y[mbt_pkg::COORD_W-1:0]) * 32'(MAX_WIDTH) +
        32'(probe.x[mbt_pkg::COORD_W-1:0])) : '0;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= wr.on;
    end
    rd_bit    <= mem[raddr];
    in_area_q <= in_area;
  end

  assign hit = in_area_q && rd_bit;

endmodule

/* hw/rtl/moore_boundary_tracer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moore_boundary_tracer_top: Moore-neighbour outer boundary tracer
// Loads a one-bit image by pixel beats and returns one result beat per
// request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): kind 0 writes one pixel, kind 1
//   asks for the next boundary point, kind 2 restarts the trace (image kept).
//   Only kind 1 produces an output beat (out_valid / out_stall).
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 width,
//   1 height, 2 point limit. Write only while the block is idle.
//   Sequence: writes, restarts and unused kinds are taken in idle and leave
//   the block idle. A request is taken in idle, latches the point, then
//   probes the eight neighbours in turn through the single image read port
//   (one probe per cycle, read data registered) until one is set, then
//   raises the output beat. With the trace ended or blank the beat follows
//   the request directly; at the point limit it follows the point latch.
//   The first request of a trace also scans the area column by column, one
//   pixel per cycle, until it finds a set pixel or the area ends.
//   in_stall is high from the accepted request until its result is taken;
//   one item is in flight at a time, the next is taken the cycle after.
//   Reset: registers return to 64 x 64 and 4096 points, the trace is
//   cleared; image contents are undefined until written.
//   A stalled output beat holds its payload until taken.
// ----------------------------------------------------------------------------
module moore_boundary_tracer_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  input  logic        pixel_on,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  point_x,
  output logic [5:0]  point_y,
  output logic [12:0] point_index,
  output logic        point_valid,
  output logic        last_point,
  output logic        blank_image,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int CW = mbt_pkg::COORD_W;

  mbt_pkg::state_t state, state_next;
  mbt_pkg::phase_t phase;

  // config registers
  logic [6:0]  image_width;
  logic [6:0]  image_height;
  logic [13:0] max_points;

  // trace state
  logic [CW-1:0]               cur_col, cur_row;
  logic [CW-1:0]               start_col, start_row;
  logic [2:0]                  back_dir;
  logic [mbt_pkg::COUNT_W-1:0] emitted_count;

  // scan / probe sequencing
  logic [CW-1:0] scan_x, scan_y;
  logic          issue_done;
  logic [3:0]    ni;
  logic          pend_valid;
  logic [CW-1:0] pend_x, pend_y;
  logic [2:0]    pend_dir;

  logic [CW-1:0] area_w, area_h;
  logic          area_zero;
  logic          in_fire;
  logic          hit;
  logic          pend_hit;
  logic          scan_issue, step_issue;
  logic          scan_found, scan_blank, step_hit, step_none;
  logic [2:0]    nb_dir;
  logic signed [CW:0] nb_x, nb_y;
  logic [mbt_pkg::LIMIT_W-1:0] count14, limit14;
  logic          emit_last;

  mbt_pkg::wr_t    wr;
  mbt_pkg::probe_t probe;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != mbt_pkg::ST_IDLE);
  assign out_valid = (state == mbt_pkg::ST_OUT);
  assign in_fire   = in_valid && !in_stall;

  assign area_w    = (32'(image_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : image_width;
  assign area_h    = (32'(image_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : image_height;
  assign area_zero = (area_w == '0) || (area_h == '0);

  // point limit: zero acts as one, capped at 8192
  assign limit14   = (max_points == '0) ? 14'd1 :
                     ((max_points > mbt_pkg::POINT_CAP) ? mbt_pkg::POINT_CAP : max_points);
  assign count14   = {1'b0, emitted_count} + 14'd1;
  assign emit_last = (count14 >= limit14);

  // neighbour under test: clockwise from one past the backtrace
  assign nb_dir = back_dir + 3'd1 + ni[2:0];
  assign nb_x   = $signed({1'b0, cur_col}) + (CW+1)'(mbt_pkg::STEP_DX[nb_dir]);
  assign nb_y   = $signed({1'b0, cur_row}) + (CW+1)'(mbt_pkg::STEP_DY[nb_dir]);

  assign pend_hit   = pend_valid && hit;
  assign scan_issue = (state == mbt_pkg::ST_SCAN) && !issue_done && !pend_hit;
  assign step_issue = (state == mbt_pkg::ST_STEP) && (ni != 4'd8) && !pend_hit;

  always_comb begin
    if (state == mbt_pkg::ST_STEP) begin
      probe.x = nb_x;
      probe.y = nb_y;
    end else begin
      probe.x = $signed({1'b0, scan_x});
      probe.y = $signed({1'b0, scan_y});
    end
  end

  assign wr.en = in_fire && (kind == mbt_pkg::KIND_WRITE);
  assign wr.x  = pixel_x;
  assign wr.y  = pixel_y;
  assign wr.on = pixel_on;

  mbt_pixel_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .wr    (wr),
    .probe (probe),
    .area_w(area_w),
    .area_h(area_h),
    .hit   (hit)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_found = 1'b0;
    scan_blank = 1'b0;
    step_hit   = 1'b0;
    step_none  = 1'b0;
    unique case (state)
      mbt_pkg::ST_IDLE: begin
        if (in_fire && kind == mbt_pkg::KIND_NEXT) begin
          unique case (phase)
            mbt_pkg::PH_IDLE:    state_next = area_zero ? mbt_pkg::ST_OUT : mbt_pkg::ST_SCAN;
            mbt_pkg::PH_TRACING: state_next = mbt_pkg::ST_EMIT;
            mbt_pkg::PH_DONE:    state_next = mbt_pkg::ST_OUT;
            mbt_pkg::PH_BLANK:   state_next = mbt_pkg::ST_OUT;
          endcase
        end
      end
      mbt_pkg::ST_SCAN: begin
        if (pend_hit) begin
          scan_found = 1'b1;
          state_next = mbt_pkg::ST_EMIT;
        end else if (issue_done && !pend_valid) begin
          scan_blank = 1'b1;
          state_next = mbt_pkg::ST_OUT;
        end
      end
      mbt_pkg::ST_EMIT: begin
        state_next = emit_last ? mbt_pkg::ST_OUT : mbt_pkg::ST_STEP;
      end
      mbt_pkg::ST_STEP: begin
        if (pend_hit) begin
          step_hit   = 1'b1;
          state_next = mbt_pkg::ST_OUT;
        end else if (ni == 4'd8 && !pend_valid) begin
          step_none  = 1'b1;
          state_next = mbt_pkg::ST_OUT;
        end
      end
      mbt_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = mbt_pkg::ST_IDLE;
        end
      end
      default: state_next = mbt_pkg::ST_IDLE;
    endcase
  end

  // control and trace state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 7'd64;
      image_height  <= 7'd64;
      max_points    <= 14'd4096;
      phase         <= mbt_pkg::PH_IDLE;
      cur_col       <= '0;
      cur_row       <= '0;
      start_col     <= '0;
      start_row     <= '0;
      back_dir      <= '0;
      emitted_count <= '0;
      scan_x        <= '0;
      scan_y        <= '0;
      issue_done    <= 1'b0;
      ni            <= '0;
      pend_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbt_pkg::REG_WIDTH:  image_width  <= cfg_data[6:0];
          mbt_pkg::REG_HEIGHT: image_height <= cfg_data[6:0];
          mbt_pkg::REG_MAXPTS: max_points   <= cfg_data;
          default: ;
        endcase
      end

      pend_valid <= scan_issue || step_issue;

      // column-major scan counters
      if (scan_issue) begin
        if (scan_y == area_h - CW'(1)) begin
          scan_y <= '0;
          if (scan_x == area_w - CW'(1)) begin
            issue_done <= 1'b1;
          end else begin
            scan_x <= scan_x + CW'(1);
          end
        end else begin
          scan_y <= scan_y + CW'(1);
        end
      end

      if (step_issue) begin
        ni <= ni + 4'd1;
      end

      if (state == mbt_pkg::ST_IDLE && in_fire) begin
        if (kind == mbt_pkg::KIND_RESTART) begin
          phase         <= mbt_pkg::PH_IDLE;
          cur_col       <= '0;
          cur_row       <= '0;
          start_col     <= '0;
          start_row     <= '0;
          back_dir      <= '0;
          emitted_count <= '0;
        end else if (kind == mbt_pkg::KIND_NEXT && phase == mbt_pkg::PH_IDLE) begin
          scan_x     <= '0;
          scan_y     <= '0;
          issue_done <= 1'b0;
          if (area_zero) begin
            phase <= mbt_pkg::PH_BLANK;
          end
        end
      end

      if (scan_found) begin
        cur_col       <= pend_x;
        cur_row       <= pend_y;
        start_col     <= pend_x;
        start_row     <= pend_y;
        back_dir      <= (pend_x == '0) ? 3'd1 : 3'd7;
        emitted_count <= '0;
        phase         <= mbt_pkg::PH_TRACING;
      end

      if (scan_blank) begin
        phase <= mbt_pkg::PH_BLANK;
      end

      if (state == mbt_pkg::ST_EMIT) begin
        emitted_count <= count14[mbt_pkg::COUNT_W-1:0];
        ni            <= '0;
        if (emit_last) begin
          phase <= mbt_pkg::PH_DONE;
        end
      end

      if (step_hit) begin
        cur_col  <= pend_x;
        cur_row  <= pend_y;
        back_dir <= pend_dir + 3'd4;
        if (pend_x == start_col && pend_y == start_row) begin
          phase <= mbt_pkg::PH_DONE;
        end
      end

      if (step_none && cur_col == start_col && cur_row == start_row) begin
        phase <= mbt_pkg::PH_DONE;
      end
    end
  end

  // probe tags and output payload
  always_ff @(posedge clk) begin
    if (scan_issue || step_issue) begin
      pend_x   <= probe.x[CW-1:0];
      pend_y   <= probe.y[CW-1:0];
      pend_dir <= nb_dir;
    end

    if (state == mbt_pkg::ST_IDLE && in_fire && kind == mbt_pkg::KIND_NEXT) begin
      point_x     <= '0;
      point_y     <= '0;
      point_index <= '0;
      point_valid <= 1'b0;
      last_point  <= 1'b0;
      blank_image <= (phase == mbt_pkg::PH_BLANK) ||
                     (phase == mbt_pkg::PH_IDLE && area_zero);
    end

    if (scan_blank) begin
      blank_image <= 1'b1;
    end

    if (state == mbt_pkg::ST_EMIT) begin
      point_x     <= cur_col[5:0];
      point_y     <= cur_row[5:0];
      point_index <= emitted_count;
      point_valid <= 1'b1;
      last_point  <= emit_last;
      blank_image <= 1'b0;
    end

    if (step_hit) begin
      last_point <= (pend_x == start_col) && (pend_y == start_row);
    end

    if (step_none) begin
      last_point <= (cur_col == start_col) && (cur_row == start_row);
    end
  end

endmodule

/* hw/rtl/mbt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_port_checker: port-level checks for the boundary tracer
// Watches the top-level channels and the result beat's flag fields.
// ----------------------------------------------------------------------------
module mbt_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  point_x,
  input logic [5:0]  point_y,
  input logic [12:0] point_index,
  input logic        point_valid,
  input logic        last_point,
  input logic        blank_image
);

  // one item in flight: no input beat while a result waits
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result beat is pending");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y) &&
      $stable(point_index) && $stable(last_point) && $stable(blank_image))
    else $error("stalled result beat changed");

  // blank flag never comes with a point
  a_blank_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && blank_image |-> !point_valid && !last_point)
    else $error("blank image beat carries a point");

  // trace end is always marked on a real point
  a_last_has_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> point_valid)
    else $error("last point flagged without a point");

endmodule

bind moore_boundary_tracer_top mbt_port_checker u_mbt_checker (.*);
